// File: rtl/core/qpd_pkg.sv
package qpd_pkg;

   localparam logic [7:0] EqChar = 8'h3D;
   localparam logic [7:0] CrChar = 8'h0D;
   localparam logic [7:0] LfChar = 8'h0A;

   localparam int QueueDepth = 4;
   localparam int PtrWidth   = $clog2(QueueDepth);
   localparam int CountWidth = $clog2(QueueDepth + 1);

   typedef enum logic [1:0] {
      PendNone = 2'd0,
      PendEq   = 2'd1,
      PendHeld = 2'd2
   } pend_type;

   // up to three results produced by one input word
   typedef struct packed {
      logic [1:0]      cnt;
      logic [2:0][7:0] bytes;
      logic            has_data;
      logic            eom;
   } pkt_type;

   typedef struct packed {
      logic [3:0] value;
      logic       valid;
   } hex_type;

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type r;
      r.valid = 1'b0;
      r.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.valid = 1'b1;
         r.value = c[3:0];
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         r.valid = 1'b1;
         r.value = 4'(c[2:0] + 3'd1) + 4'd8;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/qpd_front.sv
module qpd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [7:0]        req_in_byte,
   input  logic              req_last,
   input  logic              full,
   output logic              push,
   output qpd_pkg::pkt_type  pkt
);

   qpd_pkg::pend_type pend_ff, pend_in;
   logic [7:0]        held_ff, held_in;
   logic              accept;
   qpd_pkg::hex_type  hex_b, hex_h;
   logic              b_is_eq;

   assign accept  = req_valid && !full;
   assign hex_b   = qpd_pkg::hex_digit(req_in_byte);
   assign hex_h   = qpd_pkg::hex_digit(held_ff);
   assign b_is_eq = (req_in_byte == qpd_pkg::EqChar) && !req_last;
   assign push    = accept && (pkt.cnt != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= qpd_pkg::PendNone;
         held_ff <= 8'd0;
      end else if (accept) begin
         pend_ff <= pend_in;
         held_ff <= held_in;
      end
   end

   always_comb begin
      pend_in      = qpd_pkg::PendNone;
      held_in      = held_ff;
      pkt.cnt      = 2'd0;
      pkt.bytes    = '0;
      pkt.has_data = 1'b1;
      pkt.eom      = req_last;
      case (pend_ff)
         qpd_pkg::PendEq: begin
            if (!req_last && req_in_byte == qpd_pkg::LfChar) begin
               // soft break, nothing out
            end else if (!req_last && (req_in_byte == qpd_pkg::CrChar || hex_b.valid)) begin
               held_in = req_in_byte;
               pend_in = qpd_pkg::PendHeld;
            end else begin
               pkt.bytes[0] = qpd_pkg::EqChar;
               if (b_is_eq) begin
                  pend_in = qpd_pkg::PendEq;
                  pkt.cnt = 2'd1;
               end else begin
                  pkt.bytes[1] = req_in_byte;
                  pkt.cnt      = 2'd2;
               end
            end
         end
         qpd_pkg::PendHeld: begin
            if (held_ff == qpd_pkg::CrChar && req_in_byte == qpd_pkg::LfChar) begin
               if (req_last) begin
                  pkt.cnt      = 2'd1;
                  pkt.has_data = 1'b0;
               end
            end else if (hex_h.valid && hex_b.valid) begin
               pkt.bytes[0] = {hex_h.value, hex_b.value};
               pkt.cnt      = 2'd1;
            end else begin
               // failed escape: '=' then the held byte again as plain input
               pkt.bytes[0] = qpd_pkg::EqChar;
               pkt.bytes[1] = held_ff;
               if (b_is_eq) begin
                  pend_in = qpd_pkg::PendEq;
                  pkt.cnt = 2'd2;
               end else begin
                  pkt.bytes[2] = req_in_byte;
                  pkt.cnt      = 2'd3;
               end
            end
         end
         default: begin
            if (b_is_eq) begin
               pend_in = qpd_pkg::PendEq;
            end else begin
               pkt.bytes[0] = req_in_byte;
               pkt.cnt      = 2'd1;
            end
         end
      endcase
      if (req_last) begin
         pend_in = qpd_pkg::PendNone;
         held_in = 8'd0;
      end
   end

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_last |=> pend_ff == qpd_pkg::PendNone)
      else $error("pending state survives end of message");

   a_eom_last: assert property (@(posedge clock) disable iff (reset)
      push |-> pkt.eom == req_last)
      else $error("end marker does not follow last input");

endmodule

// File: rtl/core/qpd_queue.sv
module qpd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  qpd_pkg::pkt_type  push_pkt,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output qpd_pkg::pkt_type  head_pkt
);

   qpd_pkg::pkt_type                  mem_ff [qpd_pkg::QueueDepth];
   logic [qpd_pkg::PtrWidth-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [qpd_pkg::CountWidth-1:0]    count_ff, count_in;

   assign full       = (count_ff == qpd_pkg::CountWidth'(qpd_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_pkt   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_pkt;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("queue read while empty");

endmodule

// File: rtl/core/qpd_back.sv
module qpd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  qpd_pkg::pkt_type  head_pkt,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_has_data,
   output logic              rsp_end_of_message
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       has_ff, has_in;
   logic       eom_ff, eom_in;
   logic       out_free, take, last_of_pkt;

   assign out_free    = !valid_ff || !rsp_stall;
   assign take        = out_free && head_valid;
   assign last_of_pkt = (idx_ff == head_pkt.cnt - 2'd1);
   assign pop         = take && last_of_pkt;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      has_in   = has_ff;
      eom_in   = eom_ff;
      if (out_free) begin
         valid_in = head_valid;
      end
      if (take) begin
         byte_in = head_pkt.bytes[idx_ff];
         has_in  = head_pkt.has_data;
         eom_in  = head_pkt.eom && last_of_pkt;
         idx_in  = last_of_pkt ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      has_ff  <= has_in;
      eom_ff  <= eom_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_byte       = byte_ff;
   assign rsp_has_data       = has_ff;
   assign rsp_end_of_message = eom_ff;

   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> idx_ff == 2'd0)
      else $error("word index left over with empty queue");

endmodule

// File: rtl/core/quoted_printable_decoder.sv
// quoted-printable decoder, one encoded byte per word on the req_ channel
// (req_in_byte plus req_last on the final byte of a message) and one decoded
// byte per word on the rsp_ channel (rsp_out_byte, rsp_has_data low only for a
// bare end marker, rsp_end_of_message on the last word of the message).
// a word is taken on a rising edge with valid high and stall low.
// the front stage classifies each byte against the pending '=' and held byte
// and writes zero to three results into a four-entry queue; the back stage
// drains the queue into the output register, one word per cycle while rsp_stall is low.
// an accepted byte's results are written into the queue and then into the
// output register; rsp_valid rises once the first of them is in that register.
// throughput: one input byte per cycle while rsp_stall is low and each byte
// gives at most one result; a failed escape gives two or three results and the
// output side, at one word per cycle, then sets the pace until the queue drains.
// req_stall rises only when the queue is full, so a stalled receiver fills
// the queue and then holds off the sender; nothing is dropped.
// reset (synchronous, active high) empties the queue and output register
// and clears any pending escape.
module quoted_printable_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_data,
   output logic       rsp_end_of_message
);

   qpd_pkg::pkt_type push_pkt, head_pkt;
   logic             push, pop, full, head_valid;

   assign req_stall = full;

   qpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_last    (req_last),
      .full        (full),
      .push        (push),
      .pkt         (push_pkt)
   );

   qpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_pkt   (push_pkt),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_pkt   (head_pkt)
   );

   qpd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_pkt           (head_pkt),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_has_data       (rsp_has_data),
      .rsp_end_of_message (rsp_end_of_message)
   );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int RandomItems = 290;
   localparam int LongHold    = 150;
   localparam int TailCycles  = 20;
   localparam int CycleLimit  = 400000;
   localparam int HexRadix    = 16;

   typedef struct packed {
      logic [7:0] b;
      logic       last;
   } encoded_word_type;

   localparam int DirectedLen = 27;
   localparam encoded_word_type Directed [DirectedLen] = '{
      // byte extremes
      '{8'h00, 1'b0}, '{8'hFF, 1'b1},
      // escapes in both cases, the second one closing the message
      '{qpd_pkg::EqChar, 1'b0}, '{"4", 1'b0}, '{"a", 1'b0},
      '{qpd_pkg::EqChar, 1'b0}, '{"F", 1'b0}, '{"0", 1'b1},
      // soft breaks of both kinds, then a lone '=' as the final byte
      '{qpd_pkg::EqChar, 1'b0}, '{qpd_pkg::CrChar, 1'b0}, '{qpd_pkg::LfChar, 1'b0},
      '{qpd_pkg::EqChar, 1'b0}, '{qpd_pkg::LfChar, 1'b0}, '{qpd_pkg::EqChar, 1'b1},
      // '==', blank after '=', sign as second digit, soft break ending the message
      '{qpd_pkg::EqChar, 1'b0}, '{qpd_pkg::EqChar, 1'b0}, '{" ", 1'b0},
      '{qpd_pkg::EqChar, 1'b0}, '{"A", 1'b0}, '{"-", 1'b0},
      '{qpd_pkg::EqChar, 1'b0}, '{qpd_pkg::CrChar, 1'b0}, '{qpd_pkg::LfChar, 1'b1},
      // short escapes cut off by the end of the message
      '{qpd_pkg::EqChar, 1'b0}, '{"B", 1'b1},
      '{qpd_pkg::EqChar, 1'b0}, '{qpd_pkg::LfChar, 1'b1}
   };

   class decoded_stream_board;
      typedef struct {
         logic [7:0] data;
         logic       has_data;
         logic       eom;
      } decoded_type;

      decoded_type         decoded_q[$];
      qpd_pkg::pend_type   pend;
      logic [7:0]          held;
      int                  errors;

      function new();
         pend   = qpd_pkg::PendNone;
         held   = 8'h00;
         errors = 0;
      endfunction

      function int hex_value(logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c - "0");
         if (c >= "A" && c <= "F") return int'(c - "A") + 10;
         if (c >= "a" && c <= "f") return int'(c - "a") + 10;
         return -1;
      endfunction

      function void push(logic [7:0] b, logic has, logic eom);
         decoded_type w;
         w.data     = has ? b : 8'h00;
         w.has_data = has;
         w.eom      = eom;
         decoded_q  = {decoded_q, w};
      endfunction

      function void plain(logic [7:0] b, logic last);
         if (b == qpd_pkg::EqChar && !last) pend = qpd_pkg::PendEq;
         else push(b, 1'b1, last);
      endfunction

      function void take_encoded(logic [7:0] b, logic last);
         qpd_pkg::pend_type prev;
         logic [7:0]        h;
         int                hi;
         int                lo;
         prev = pend;
         h    = held;
         pend = qpd_pkg::PendNone;
         case (prev)
            qpd_pkg::PendEq: begin
               if (!last && b == qpd_pkg::LfChar) begin
                  // soft break, nothing out
               end else if (!last && (b == qpd_pkg::CrChar || hex_value(b) >= 0)) begin
                  held = b;
                  pend = qpd_pkg::PendHeld;
               end else begin
                  push(qpd_pkg::EqChar, 1'b1, 1'b0);
                  plain(b, last);
               end
            end
            qpd_pkg::PendHeld: begin
               hi = hex_value(h);
               lo = hex_value(b);
               if (h == qpd_pkg::CrChar && b == qpd_pkg::LfChar) begin
                  if (last) push(8'h00, 1'b0, 1'b1);
               end else if (hi >= 0 && lo >= 0) begin
                  push(8'(hi * HexRadix + lo), 1'b1, last);
               end else begin
                  // failed escape: '=' then the held byte and this one as plain input
                  push(qpd_pkg::EqChar, 1'b1, 1'b0);
                  plain(h, 1'b0);
                  plain(b, last);
               end
            end
            default: plain(b, last);
         endcase
         if (last) begin
            pend = qpd_pkg::PendNone;
            held = 8'h00;
         end
      endfunction

      function void check_decoded(logic [7:0] b, logic has, logic eom);
         decoded_type w;
         if (decoded_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected word: byte %02h has_data %0b eom %0b", b, has, eom);
            return;
         end
         w = decoded_q.pop_front();
         if (w.data !== b || w.has_data !== has || w.eom !== eom) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected byte %02h has_data %0b eom %0b, got %02h %0b %0b",
                        w.data, w.has_data, w.eom, b, has, eom);
         end
      endfunction

      function void close_out();
         if (decoded_q.size() != 0) begin
            errors++;
            if (errors <= 10)
               $display("%0d decoded words never arrived", decoded_q.size());
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       req_last;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_data;
   logic       rsp_end_of_message;

   decoded_stream_board board = new();
   int  items_sent    = 0;
   int  send_run_left = 0;
   int  cycles        = 0;
   bit  long_hold_due = 1'b0;

   quoted_printable_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_has_data       (rsp_has_data),
      .rsp_end_of_message (rsp_end_of_message)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input logic [7:0] b, input logic last);
      int gap;
      if (send_run_left > 0) begin
         gap = 0;
         send_run_left--;
      end else if ($urandom_range(0, 15) == 0) begin
         send_run_left = $urandom_range(10, 40);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 10);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_last    <= last;
      do @(posedge clock); while (req_stall);
      board.take_encoded(b, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (board.decoded_q.size() != 0);
   endtask

   function automatic logic [7:0] hex_char();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return 8'("0" + r);
      if (r < 16) return 8'("a" + r - 10);
      return 8'("A" + r - 16);
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 5))
         0:       return qpd_pkg::EqChar;
         1:       return hex_char();
         2:       return qpd_pkg::CrChar;
         3:       return qpd_pkg::LfChar;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly well-formed tokens, with some broken escapes mixed in
   task automatic send_random_message();
      logic [7:0] msg[$];
      int         ntok;
      ntok = $urandom_range(1, 8);
      repeat (ntok) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: msg = {msg, 8'($urandom_range(0, 255))};
            4, 5: begin
               msg = {msg, qpd_pkg::EqChar, hex_char(), hex_char()};
            end
            6: begin
               msg = {msg, qpd_pkg::EqChar, qpd_pkg::CrChar, qpd_pkg::LfChar};
            end
            7: begin
               msg = {msg, qpd_pkg::EqChar, qpd_pkg::LfChar};
            end
            8: begin
               msg = {msg, qpd_pkg::EqChar, noise_byte()};
            end
            default: begin
               msg = {msg, qpd_pkg::EqChar, hex_char(), noise_byte()};
            end
         endcase
      end
      foreach (msg[i]) send_word(msg[i], i == msg.size() - 1);
   endtask

   initial begin : receiver
      int gap;
      int run_left;
      rsp_stall = 1'b0;
      run_left  = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_due) begin
            // long hold so the queue fills and the input backs up
            gap = LongHold;
            long_hold_due = 1'b0;
         end else if (run_left > 0) begin
            gap = 0;
            run_left--;
         end else if ($urandom_range(0, 15) == 0) begin
            run_left = $urandom_range(10, 40);
            gap = 0;
         end else begin
            gap = $urandom_range(0, 10);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         board.check_decoded(rsp_out_byte, rsp_has_data, rsp_end_of_message);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      bit hold_done;
      bit paused;
      hold_done   = 1'b0;
      paused      = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = 8'h00;
      req_last    = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < DirectedLen; k++)
         send_word(Directed[k].b, Directed[k].last);
      pause_until_drained();

      while (items_sent < DirectedLen + RandomItems) begin
         if (!hold_done && items_sent > DirectedLen + 60) begin
            long_hold_due = 1'b1;
            hold_done     = 1'b1;
         end
         if ((!paused && items_sent > DirectedLen + 180) || $urandom_range(0, 15) == 0) begin
            pause_until_drained();
            paused = 1'b1;
         end
         send_random_message();
      end

      req_valid <= 1'b0;
      while (board.decoded_q.size() != 0) @(negedge clock);
      repeat (TailCycles) @(negedge clock);
      board.close_out();
      if (board.errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/qpd_pkg.sv
rtl/core/qpd_front.sv
rtl/core/qpd_queue.sv
rtl/core/qpd_back.sv
rtl/core/quoted_printable_decoder.sv
bench/tb_top.sv
